@@ sv/sgn_pkg.sv @@
// Shared types and constants for the sparse gene network forward block.
// No dependencies; only the top level refers to this package, by scoped names.
package sgn_pkg;

    localparam int SENSOR_SLOTS = 16;
    localparam int SENSOR_AW    = 4;
    localparam int MAX_OUTPUTS  = 8;
    localparam int CFG_DATA_W   = 5;
    localparam int GENE_W       = 21;   // innovation(4) weight(16) disabled(1)
    localparam int INNOV_W      = 8;    // source(4) target(4)

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    localparam logic [3:0] SENSOR_COUNT_RST = 4'd3;
    localparam logic [3:0] OUTPUT_COUNT_RST = 4'd2;
    localparam logic [4:0] GENE_COUNT_RST   = 5'd0;
    localparam logic [3:0] HIGHEST_NODE_RST = 4'd8;

    typedef enum logic [1:0] {
        REQ_GENE   = 2'd0,
        REQ_INNOV  = 2'd1,
        REQ_SENSOR = 2'd2,
        REQ_EVAL   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_SENSOR_COUNT = 2'd0,
        CFG_OUTPUT_COUNT = 2'd1,
        CFG_GENE_COUNT   = 2'd2,
        CFG_HIGHEST_NODE = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SEN_RD,
        ST_SEN_WR,
        ST_GENE_RD,
        ST_GENE_CHK,
        ST_NODE_RD,
        ST_SRC,
        ST_ACC,
        ST_OUT_RD,
        ST_OUT_WR
    } t_state;

endpackage

@@ sv/sgn_req_if.sv @@
// Request channel: one beat carries a load or an evaluate request.
// Depends on nothing; used by the top level as its input port.
interface sgn_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [3:0]         slot;
    logic [3:0]         gene_innovation;
    logic signed [15:0] weight;
    logic               disabled;
    logic [3:0]         src_node;
    logic [3:0]         to_node;
    logic signed [15:0] sensor_value;

    modport source (
        output valid, req_type, slot, gene_innovation, weight, disabled,
               src_node, to_node, sensor_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, slot, gene_innovation, weight, disabled,
               src_node, to_node, sensor_value,
        output ready
    );
endinterface

@@ sv/sgn_res_if.sv @@
// Result channel: one beat per output node of an evaluation.
// Depends on nothing; used by the top level as its output port.
interface sgn_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         output_index;
    logic signed [31:0] output_value;
    logic               order_fault;
    logic               last;

    modport source (
        output valid, output_index, output_value, order_fault, last,
        input  ready
    );
    modport sink (
        input  valid, output_index, output_value, order_fault, last,
        output ready
    );
endinterface

@@ sv/sgn_ram.sv @@
// Generic single-write, single-read memory with registered read data.
// No package dependency.
module sgn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/sgn_node_ram.sv @@
// Node value store: one write port, two registered read ports.
// No package dependency; validity of entries is tracked by the caller.
module sgn_node_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic signed [31:0] i_wdata,
    input  logic               i_re_a,
    input  logic [AW-1:0]      i_raddr_a,
    output logic signed [31:0] o_rdata_a,
    input  logic               i_re_b,
    input  logic [AW-1:0]      i_raddr_b,
    output logic signed [31:0] o_rdata_b
);
    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata_a;
    logic signed [31:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

@@ sv/sgn_mac.sv @@
// Shared multiply-accumulate unit: Q8.8 x Q16.16 product registered,
// then floor-shifted to Q16.16, added to the target and saturated. No deps.
module sgn_mac (
    input  logic               i_clk,
    input  logic               i_mul_en,
    input  logic signed [15:0] i_weight,
    input  logic signed [31:0] i_src,
    input  logic signed [31:0] i_acc,
    output logic signed [31:0] o_sum
);
    logic signed [47:0] r_prod;
    logic signed [40:0] w_sum;

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= i_weight * i_src;
        end
    end

    always_comb begin
        w_sum = 41'(i_acc) + 41'($signed(r_prod[47:8]));
        if (!w_sum[40] && (|w_sum[39:31])) begin
            o_sum = 32'sh7FFF_FFFF;
        end else if (w_sum[40] && !(&w_sum[39:31])) begin
            o_sum = -32'sh7FFF_FFFF - 32'sd1;
        end else begin
            o_sum = w_sum[31:0];
        end
    end
endmodule

@@ sv/sparse_gene_network_forward.sv @@
// Top level of the sparse gene network forward block: sequencer, stores,
// configuration registers and result register. Uses sgn_pkg, the interfaces,
// sgn_ram, sgn_node_ram and sgn_mac.
//
//  Channel   Direction  Beat contents
//  i_req     in         req_type, slot, gene_innovation, weight, disabled,
//                       src_node, to_node, sensor_value
//  o_res     out        output_index, output_value, order_fault, last
//  i_cfg_*   in         write enable, register index, write data (no handshake)
//
// A load is written to its store as it is accepted and leaves the block ready.
// An evaluate seeds the bias and sensor nodes, walks the genes (gene read,
// check, innovation read, node reads, source, accumulate; a disabled or faulty
// gene leaves early), then emits each output node while the sink keeps up.
// i_req.ready is high only while the sequencer is idle. A stalled o_res beat
// holds the sequencer at its next output. Reset clears control state and the
// node valid/activated bits; the gene, innovation and sensor stores are not
// cleared and read as undefined until written.
module sparse_gene_network_forward #(
    parameter int NODE_SLOTS       = 16,
    parameter int GENE_SLOTS       = 16,
    parameter int INNOVATION_SLOTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sgn_req_if.sink                           i_req,
    sgn_res_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [sgn_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int NW = $clog2(NODE_SLOTS);
    localparam int GW = (GENE_SLOTS > 1) ? $clog2(GENE_SLOTS) : 1;
    localparam int IW = (INNOVATION_SLOTS > 1) ? $clog2(INNOVATION_SLOTS) : 1;

    // configuration registers
    logic [3:0] r_sc, r_oc, r_hn;
    logic [4:0] r_gc;

    // sequencer state
    sgn_pkg::t_state r_state, n_state;
    logic [4:0]      r_si, n_si;      // sensor node being seeded
    logic [4:0]      r_gi, n_gi;      // gene slot being walked
    logic [2:0]      r_oi, n_oi;      // output number
    logic [NW-1:0]   r_src, n_src;
    logic [NW-1:0]   r_dst, n_dst;
    logic            r_fault, n_fault;
    logic [NODE_SLOTS-1:0] r_vld, n_vld;   // node holds a written value
    logic [NODE_SLOTS-1:0] r_act, n_act;   // node activated

    // result register
    logic               r_res_vld, n_res_vld;
    logic [2:0]         r_res_idx, n_res_idx;
    logic signed [31:0] r_res_val, n_res_val;
    logic               r_res_fault, n_res_fault;
    logic               r_res_last, n_res_last;

    // store ports
    logic                       w_req_acc;
    logic                       w_g_we, w_g_re;
    logic [sgn_pkg::GENE_W-1:0] w_g_rd;
    logic                       w_i_we, w_i_re;
    logic [sgn_pkg::INNOV_W-1:0] w_i_rd;
    logic                       w_s_we, w_s_re;
    logic [15:0]                w_s_rd;
    logic [sgn_pkg::SENSOR_AW-1:0] w_s_raddr;

    logic                 w_n_we, w_n_re_a, w_n_re_b;
    logic [NW-1:0]        w_n_waddr, w_n_raddr_a, w_n_raddr_b;
    logic signed [31:0]   w_n_wdata, w_n_rd_a, w_n_rd_b;

    logic                 w_mul_en;
    logic signed [31:0]   w_mac_src, w_mac_acc, w_mac_sum;

    // decoded fields
    logic [3:0]         w_g_innov;
    logic signed [15:0] w_g_weight;
    logic               w_g_dis;
    logic [3:0]         w_i_src, w_i_dst;
    logic [3:0]         w_nout;
    logic [4:0]         w_onode;
    logic               w_onode_ok;
    logic               w_olast;
    logic signed [31:0] w_src_raw;

    function automatic logic f_node_ok(input logic [3:0] n, input logic [3:0] hi);
        return (32'(n) < NODE_SLOTS) && (n <= hi);
    endfunction

    assign w_req_acc  = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == sgn_pkg::ST_IDLE);

    // load writes go straight to the stores
    assign w_g_we = w_req_acc && (i_req.req_type == sgn_pkg::REQ_GENE)
                    && (32'(i_req.slot) < GENE_SLOTS);
    assign w_i_we = w_req_acc && (i_req.req_type == sgn_pkg::REQ_INNOV)
                    && (32'(i_req.slot) < INNOVATION_SLOTS);
    assign w_s_we = w_req_acc && (i_req.req_type == sgn_pkg::REQ_SENSOR);

    assign w_g_innov  = w_g_rd[20:17];
    assign w_g_weight = w_g_rd[16:1];
    assign w_g_dis    = w_g_rd[0];
    assign w_i_src    = w_i_rd[7:4];
    assign w_i_dst    = w_i_rd[3:0];

    // output count clamped to 1..8
    always_comb begin
        if (r_oc == 4'd0) begin
            w_nout = 4'd1;
        end else if (32'(r_oc) > sgn_pkg::MAX_OUTPUTS) begin
            w_nout = 4'(sgn_pkg::MAX_OUTPUTS);
        end else begin
            w_nout = r_oc;
        end
    end

    assign w_onode    = 5'(r_sc) + 5'd1 + 5'(r_oi);
    assign w_onode_ok = 32'(w_onode) < NODE_SLOTS;
    assign w_olast    = (4'(r_oi) + 4'd1) == w_nout;
    assign w_s_raddr  = sgn_pkg::SENSOR_AW'(r_si - 5'd1);
    assign w_src_raw  = r_vld[r_src] ? w_n_rd_a : 32'sd0;

    // sequencer: next state and datapath controls
    always_comb begin
        n_state     = r_state;
        n_si        = r_si;
        n_gi        = r_gi;
        n_oi        = r_oi;
        n_src       = r_src;
        n_dst       = r_dst;
        n_fault     = r_fault;
        n_vld       = r_vld;
        n_act       = r_act;
        n_res_vld   = r_res_vld;
        n_res_idx   = r_res_idx;
        n_res_val   = r_res_val;
        n_res_fault = r_res_fault;
        n_res_last  = r_res_last;

        w_g_re      = 1'b0;
        w_i_re      = 1'b0;
        w_s_re      = 1'b0;
        w_n_we      = 1'b0;
        w_n_waddr   = '0;
        w_n_wdata   = 32'sd0;
        w_n_re_a    = 1'b0;
        w_n_raddr_a = '0;
        w_n_re_b    = 1'b0;
        w_n_raddr_b = '0;
        w_mul_en    = 1'b0;
        w_mac_src   = w_src_raw;
        w_mac_acc   = r_vld[r_dst] ? w_n_rd_b : 32'sd0;

        // drop the result beat once taken
        if (r_res_vld && o_res.ready) begin
            n_res_vld = 1'b0;
        end

        case (r_state)
            sgn_pkg::ST_IDLE: begin
                if (w_req_acc && (i_req.req_type == sgn_pkg::REQ_EVAL)) begin
                    n_state = sgn_pkg::ST_INIT;
                end
            end
            sgn_pkg::ST_INIT: begin
                // zero all nodes, seed the bias node with one
                n_vld     = '0;
                n_act     = '0;
                n_vld[0]  = 1'b1;
                n_act[0]  = 1'b1;
                w_n_we    = 1'b1;
                w_n_waddr = '0;
                w_n_wdata = sgn_pkg::ONE_Q16;
                n_fault   = 1'b0;
                n_si      = 5'd1;
                n_state   = sgn_pkg::ST_SEN_RD;
            end
            sgn_pkg::ST_SEN_RD: begin
                if (r_si > 5'(r_sc)) begin
                    n_gi    = 5'd0;
                    n_state = sgn_pkg::ST_GENE_RD;
                end else begin
                    w_s_re  = 1'b1;
                    n_state = sgn_pkg::ST_SEN_WR;
                end
            end
            sgn_pkg::ST_SEN_WR: begin
                if (32'(r_si) < NODE_SLOTS) begin
                    w_n_we          = 1'b1;
                    w_n_waddr       = NW'(r_si);
                    w_n_wdata       = {w_s_rd, 16'h0000};
                    n_vld[NW'(r_si)] = 1'b1;
                    n_act[NW'(r_si)] = 1'b1;
                end
                n_si    = r_si + 5'd1;
                n_state = sgn_pkg::ST_SEN_RD;
            end
            sgn_pkg::ST_GENE_RD: begin
                if ((r_gi < r_gc) && (32'(r_gi) < GENE_SLOTS)) begin
                    w_g_re  = 1'b1;
                    n_state = sgn_pkg::ST_GENE_CHK;
                end else begin
                    n_oi    = 3'd0;
                    n_state = sgn_pkg::ST_OUT_RD;
                end
            end
            sgn_pkg::ST_GENE_CHK: begin
                if (w_g_dis) begin
                    n_gi    = r_gi + 5'd1;
                    n_state = sgn_pkg::ST_GENE_RD;
                end else if (32'(w_g_innov) >= INNOVATION_SLOTS) begin
                    n_fault = 1'b1;
                    n_gi    = r_gi + 5'd1;
                    n_state = sgn_pkg::ST_GENE_RD;
                end else begin
                    w_i_re  = 1'b1;
                    n_state = sgn_pkg::ST_NODE_RD;
                end
            end
            sgn_pkg::ST_NODE_RD: begin
                if (!f_node_ok(w_i_src, r_hn) || !f_node_ok(w_i_dst, r_hn)) begin
                    n_fault = 1'b1;
                    n_gi    = r_gi + 5'd1;
                    n_state = sgn_pkg::ST_GENE_RD;
                end else begin
                    w_n_re_a    = 1'b1;
                    w_n_raddr_a = NW'(w_i_src);
                    w_n_re_b    = 1'b1;
                    w_n_raddr_b = NW'(w_i_dst);
                    n_src       = NW'(w_i_src);
                    n_dst       = NW'(w_i_dst);
                    n_state     = sgn_pkg::ST_SRC;
                end
            end
            sgn_pkg::ST_SRC: begin
                // activate the source on first use by halving it
                if (!r_act[r_src]) begin
                    w_mac_src    = w_src_raw >>> 1;
                    w_n_we       = 1'b1;
                    w_n_waddr    = r_src;
                    w_n_wdata    = w_src_raw >>> 1;
                    n_vld[r_src] = 1'b1;
                    n_act[r_src] = 1'b1;
                end
                w_mul_en = 1'b1;
                if (r_act[r_dst] || (r_dst == r_src)) begin
                    n_fault = 1'b1;
                    n_gi    = r_gi + 5'd1;
                    n_state = sgn_pkg::ST_GENE_RD;
                end else begin
                    n_state = sgn_pkg::ST_ACC;
                end
            end
            sgn_pkg::ST_ACC: begin
                w_n_we       = 1'b1;
                w_n_waddr    = r_dst;
                w_n_wdata    = w_mac_sum;
                n_vld[r_dst] = 1'b1;
                n_gi         = r_gi + 5'd1;
                n_state      = sgn_pkg::ST_GENE_RD;
            end
            sgn_pkg::ST_OUT_RD: begin
                if (w_onode_ok) begin
                    w_n_re_a    = 1'b1;
                    w_n_raddr_a = NW'(w_onode);
                end
                n_state = sgn_pkg::ST_OUT_WR;
            end
            sgn_pkg::ST_OUT_WR: begin
                // hold until the result register is free
                if (!r_res_vld || o_res.ready) begin
                    n_res_vld   = 1'b1;
                    n_res_idx   = r_oi;
                    n_res_fault = r_fault;
                    n_res_last  = w_olast;
                    if (w_onode_ok && r_vld[NW'(w_onode)]) begin
                        n_res_val = w_n_rd_a >>> 1;
                    end else begin
                        n_res_val = 32'sd0;
                    end
                    if (w_olast) begin
                        n_state = sgn_pkg::ST_IDLE;
                    end else begin
                        n_oi    = r_oi + 3'd1;
                        n_state = sgn_pkg::ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = sgn_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sgn_pkg::ST_IDLE;
            r_vld     <= '0;
            r_act     <= '0;
            r_fault   <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_vld     <= n_vld;
            r_act     <= n_act;
            r_fault   <= n_fault;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_si        <= n_si;
        r_gi        <= n_gi;
        r_oi        <= n_oi;
        r_src       <= n_src;
        r_dst       <= n_dst;
        r_res_idx   <= n_res_idx;
        r_res_val   <= n_res_val;
        r_res_fault <= n_res_fault;
        r_res_last  <= n_res_last;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc <= sgn_pkg::SENSOR_COUNT_RST;
            r_oc <= sgn_pkg::OUTPUT_COUNT_RST;
            r_gc <= sgn_pkg::GENE_COUNT_RST;
            r_hn <= sgn_pkg::HIGHEST_NODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sgn_pkg::CFG_SENSOR_COUNT: r_sc <= i_cfg_data[3:0];
                sgn_pkg::CFG_OUTPUT_COUNT: r_oc <= i_cfg_data[3:0];
                sgn_pkg::CFG_GENE_COUNT:   r_gc <= i_cfg_data[4:0];
                sgn_pkg::CFG_HIGHEST_NODE: r_hn <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_res.valid        = r_res_vld;
    assign o_res.output_index = r_res_idx;
    assign o_res.output_value = r_res_val;
    assign o_res.order_fault  = r_res_fault;
    assign o_res.last         = r_res_last;

    sgn_ram #(
        .WIDTH (sgn_pkg::GENE_W),
        .DEPTH (GENE_SLOTS),
        .AW    (GW)
    ) u_gene_ram (
        .i_clk   (i_clk),
        .i_we    (w_g_we),
        .i_waddr (GW'(i_req.slot)),
        .i_wdata ({i_req.gene_innovation, i_req.weight, i_req.disabled}),
        .i_re    (w_g_re),
        .i_raddr (GW'(r_gi)),
        .o_rdata (w_g_rd)
    );

    sgn_ram #(
        .WIDTH (sgn_pkg::INNOV_W),
        .DEPTH (INNOVATION_SLOTS),
        .AW    (IW)
    ) u_innov_ram (
        .i_clk   (i_clk),
        .i_we    (w_i_we),
        .i_waddr (IW'(i_req.slot)),
        .i_wdata ({i_req.src_node, i_req.to_node}),
        .i_re    (w_i_re),
        .i_raddr (IW'(w_g_innov)),
        .o_rdata (w_i_rd)
    );

    sgn_ram #(
        .WIDTH (16),
        .DEPTH (sgn_pkg::SENSOR_SLOTS),
        .AW    (sgn_pkg::SENSOR_AW)
    ) u_sensor_ram (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (i_req.slot),
        .i_wdata (i_req.sensor_value),
        .i_re    (w_s_re),
        .i_raddr (w_s_raddr),
        .o_rdata (w_s_rd)
    );

    sgn_node_ram #(
        .DEPTH (NODE_SLOTS),
        .AW    (NW)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_we      (w_n_we),
        .i_waddr   (w_n_waddr),
        .i_wdata   (w_n_wdata),
        .i_re_a    (w_n_re_a),
        .i_raddr_a (w_n_raddr_a),
        .o_rdata_a (w_n_rd_a),
        .i_re_b    (w_n_re_b),
        .i_raddr_b (w_n_raddr_b),
        .o_rdata_b (w_n_rd_b)
    );

    sgn_mac u_mac (
        .i_clk    (i_clk),
        .i_mul_en (w_mul_en),
        .i_weight (w_g_weight),
        .i_src    (w_mac_src),
        .i_acc    (w_mac_acc),
        .o_sum    (w_mac_sum)
    );
endmodule
